// ----- hw/rtl/arlt_pkg.sv -----
// ----------------------------------------------------------------------------
// arlt_pkg
// Shared types and constants for the address range lookup table.
// ----------------------------------------------------------------------------
package arlt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  localparam logic [1:0] REQ_INSERT     = 2'd0;
  localparam logic [1:0] REQ_DELETE     = 2'd1;
  localparam logic [1:0] REQ_DELETE_TAG = 2'd2;
  localparam logic [1:0] REQ_LOOKUP     = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_OVERLAP = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic scan_rd;   // memory read issued this cycle
    logic scan_chk;  // read data valid this cycle
    logic commit;    // apply result
  } arlt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dummy;
  } arlt_sts_t;

endpackage

// ----- hw/rtl/address_range_lookup_table.sv -----
// ----------------------------------------------------------------------------
// address_range_lookup_table
// Bounded table of non-overlapping address ranges with insert, delete,
// delete-by-tag and lookup.
// ----------------------------------------------------------------------------
//   channel   | handshake             | payload
//   in_       | in_valid / in_ready   | req_type, address, length, tag_value
//   out_      | out_valid / out_ready | status, found_*, entry_count, removed_count
//
// Every request scans the whole table before the output beat: one
// entry per cycle is read from the table RAMs and compared.
// Reset clears the valid bits and the count at once; no clearing pass.
// A stalled result beat holds the block; the next request waits for it.
module address_range_lookup_table
  import arlt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_address,
  input  logic [31:0] in_length,
  input  logic [63:0] in_tag_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_found_start,
  output logic [31:0] out_found_length,
  output logic [63:0] out_found_tag,
  output logic [6:0]  out_entry_count,
  output logic [6:0]  out_removed_count
);
  arlt_cmd_t cmd;
  logic [$clog2(TABLE_ENTRIES)-1:0] scan_idx;

  arlt_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .scan_idx, .cmd);

  arlt_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk, .rst_n, .cmd, .scan_idx, .in_req_type, .in_address, .in_length,
    .in_tag_value, .out_status, .out_found_start, .out_found_length,
    .out_found_tag, .out_entry_count, .out_removed_count);
endmodule

// ----- hw/rtl/arlt_ram.sv -----
// ----------------------------------------------------------------------------
// arlt_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arlt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/arlt_ctrl.sv -----
// ----------------------------------------------------------------------------
// arlt_ctrl
// Request sequencer: capture, scan the table, commit, present the result.
// ----------------------------------------------------------------------------
module arlt_ctrl
  import arlt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [$clog2(TABLE_ENTRIES)-1:0] scan_idx,
  output arlt_cmd_t                        cmd
);
  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_TAIL = 3'd2;
  localparam logic [2:0] S_CMT  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign scan_idx  = idx_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd  = 1'b1;
        cmd.scan_chk = (idx_r != '0);
        if (idx_r == LAST_IDX) state_nxt = S_TAIL;
        else idx_nxt = idx_r + 1'b1;
      end
      S_TAIL: begin
        cmd.scan_chk = 1'b1;
        state_nxt    = S_CMT;
      end
      S_CMT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready and valid together");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> in_ready) else $error("load outside idle");
  a_cmt_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid) else $error("commit not followed by result");
`endif
endmodule

// ----- hw/rtl/arlt_dp.sv -----
// ----------------------------------------------------------------------------
// arlt_dp
// Table storage and scan datapath; one entry compared per cycle.
// ----------------------------------------------------------------------------
module arlt_dp
  import arlt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  arlt_cmd_t                        cmd,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] scan_idx,
  input  logic [1:0]                       in_req_type,
  input  logic [63:0]                      in_address,
  input  logic [31:0]                      in_length,
  input  logic [63:0]                      in_tag_value,
  output logic [1:0]                       out_status,
  output logic [63:0]                      out_found_start,
  output logic [31:0]                      out_found_length,
  output logic [63:0]                      out_found_tag,
  output logic [6:0]                       out_entry_count,
  output logic [6:0]                       out_removed_count
);
  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  logic [1:0]  req_r;
  logic [63:0] addr_r, last_r, tag_r;
  logic [IW-1:0] chk_idx_r;
  logic        hit_r, ovl_r, free_ok_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;
  logic [63:0] h_start_r, h_last_r, h_tag_r;
  logic [CW-1:0] count_r, removed_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic [63:0] rd_start, rd_last, rd_tag;
  logic        ram_we;
  logic [IW-1:0] ram_waddr;

  // saturating last address for inserts
  logic [31:0] len_m1;
  logic [64:0] last_sum;
  assign len_m1   = (in_length == '0) ? 32'd0 : in_length - 32'd1;
  assign last_sum = {1'b0, in_address} + {33'd0, len_m1};

  assign ram_we    = cmd.commit && (req_r == REQ_INSERT) && !ovl_r && free_ok_r;
  assign ram_waddr = free_idx_r;

  arlt_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_start (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(addr_r), .raddr(scan_idx),
    .rdata(rd_start));
  arlt_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_last (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(last_r), .raddr(scan_idx),
    .rdata(rd_last));
  arlt_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_tag (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(tag_r), .raddr(scan_idx),
    .rdata(rd_tag));

  logic v, contains, overlaps, tag_eq;
  assign v        = valid_r[chk_idx_r];
  assign contains = (addr_r >= rd_start) && (addr_r <= rd_last);
  assign overlaps = (addr_r <= rd_last) && (rd_start <= last_r);
  assign tag_eq   = (rd_tag == tag_r);

  logic [1:0] status_c;
  always_comb begin
    status_c = ST_OK;
    case (req_r)
      REQ_INSERT:     status_c = ovl_r ? ST_OVERLAP : (free_ok_r ? ST_OK : ST_FULL);
      REQ_DELETE:     status_c = hit_r ? ST_OK : ST_MISS;
      REQ_DELETE_TAG: status_c = (removed_r != '0) ? ST_OK : ST_MISS;
      REQ_LOOKUP:     status_c = hit_r ? ST_OK : ST_MISS;
      default:        status_c = ST_OK;
    endcase
  end

  logic lk;
  assign lk = (req_r == REQ_LOOKUP) && hit_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      addr_r <= in_address;
      tag_r  <= in_tag_value;
      last_r <= last_sum[64] ? '1 : last_sum[63:0];
    end
    if (cmd.scan_rd) chk_idx_r <= scan_idx;
    if (cmd.scan_chk && v && contains && !hit_r) begin
      hit_idx_r <= chk_idx_r;
      h_start_r <= rd_start;
      h_last_r  <= rd_last;
      h_tag_r   <= rd_tag;
    end
    if (cmd.scan_chk && !v && !free_ok_r) free_idx_r <= chk_idx_r;
    if (cmd.commit) begin
      out_status        <= status_c;
      out_found_start   <= lk ? h_start_r : '0;
      out_found_length  <= lk ? 32'(h_last_r - h_start_r + 64'd1) : '0;
      out_found_tag     <= lk ? h_tag_r : '0;
      // a single delete removes at most the one containing range
      out_removed_count <= (req_r == REQ_DELETE && hit_r) ? 7'd1 : 7'(removed_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      count_r   <= '0;
      hit_r     <= 1'b0;
      ovl_r     <= 1'b0;
      free_ok_r <= 1'b0;
      removed_r <= '0;
    end else begin
      if (cmd.load) begin
        hit_r     <= 1'b0;
        ovl_r     <= 1'b0;
        free_ok_r <= 1'b0;
        removed_r <= '0;
      end
      if (cmd.scan_chk) begin
        if (v && contains) hit_r <= 1'b1;
        if (v && overlaps) ovl_r <= 1'b1;
        if (!v) free_ok_r <= 1'b1;
        // delete-by-tag clears entries as it passes them
        if (req_r == REQ_DELETE_TAG && v && tag_eq) begin
          valid_r[chk_idx_r] <= 1'b0;
          removed_r <= removed_r + 1'b1;
          count_r   <= count_r - 1'b1;
        end
      end
      if (cmd.commit) begin
        if (ram_we) begin
          valid_r[free_idx_r] <= 1'b1;
          count_r <= count_r + 1'b1;
        end
        if (req_r == REQ_DELETE && hit_r) begin
          valid_r[hit_idx_r] <= 1'b0;
          count_r   <= count_r - 1'b1;
        end
      end
    end
  end

  assign out_entry_count = 7'(count_r);

`ifndef NO_ASSERTIONS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_ENTRIES)) else $error("count overflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && ram_we |=> count_r == $past(count_r) + 1'b1)
    else $error("insert count mismatch");
  a_no_wr_ovl: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ovl_r) else $error("write on overlap");
`endif
endmodule
